@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define HRSE_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define HRSE_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/hrse_pkg.sv @@
package hrse_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int TBL_IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TBL_FILL_W  = $clog2(TABLE_DEPTH + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request selector
   localparam logic [1:0] FUNC_BYTE   = 2'd0;
   localparam logic [1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_INPUT   = 2'd0;
   localparam logic [1:0] KIND_OUTPUT  = 2'd1;
   localparam logic [1:0] KIND_FEATURE = 2'd2;
   localparam logic [1:0] KIND_LOOKUP  = 2'd3;

   // result status
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_EMPTY     = 2'd2;
   localparam logic [1:0] STAT_FULL      = 2'd3;

   // descriptor item encoding
   localparam logic [7:0] LONG_PREFIX      = 8'hFE;
   localparam logic [7:0] LEN_MASK         = 8'h03;
   localparam logic [7:0] TAG_MASK         = 8'hFC;
   localparam logic [7:0] TAG_INPUT        = 8'h80;
   localparam logic [7:0] TAG_FEATURE      = 8'hB0;
   localparam logic [7:0] TAG_OUTPUT       = 8'h90;
   localparam logic [7:0] TAG_REPORT_ID    = 8'h84;
   localparam logic [7:0] TAG_REPORT_SIZE  = 8'h74;
   localparam logic [7:0] TAG_REPORT_COUNT = 8'h94;

   // only the low 19 bits of size and count reach bits 3..18 of the product
   localparam int GLOB_W = 19;

   typedef enum logic [1:0] {
      OP_RECORD,
      OP_LOOKUP,
      OP_CLEAR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [1:0]  kind;
      logic [7:0]  id;
      logic [15:0] size;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  report_id;
      logic [15:0] byte_size;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic {
      BK_IDLE,
      BK_SCAN
   } back_state_type;

endpackage

@@ rtl/hrse_front.sv @@
module hrse_front
   import hrse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [1:0] in_func,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic [7:0] in_qid,
   input  logic       queue_full,
   output logic       push,
   output cmd_type    push_cmd
);

   logic [8:0]        bytes_left_ff, bytes_left_in;
   logic [7:0]        prefix_ff, prefix_in;
   logic [1:0]        data_idx_ff, data_idx_in;
   logic [31:0]       data_ff, data_in;
   logic [7:0]        rep_id_ff, rep_id_in;
   logic [GLOB_W-1:0] rep_size_ff, rep_size_in;
   logic [GLOB_W-1:0] rep_count_ff, rep_count_in;

   logic              accept;
   logic              finish;
   logic [7:0]        fin_prefix;
   logic [31:0]       fin_data;
   logic [31:0]       merged_data;
   logic [1:0]        len;
   logic [2*GLOB_W-1:0] product;

   assign in_ready = !queue_full;
   assign accept   = in_valid && !queue_full;
   assign len      = in_byte[1:0] & LEN_MASK[1:0];

   assign merged_data = data_ff | ({24'b0, in_byte} << {data_idx_ff, 3'b000});
   assign product     = {{GLOB_W{1'b0}}, rep_size_ff} * {{GLOB_W{1'b0}}, rep_count_ff};

   always_comb begin
      bytes_left_in = bytes_left_ff;
      prefix_in     = prefix_ff;
      data_idx_in   = data_idx_ff;
      data_in       = data_ff;
      rep_id_in     = rep_id_ff;
      rep_size_in   = rep_size_ff;
      rep_count_in  = rep_count_ff;
      finish        = 1'b0;
      fin_prefix    = prefix_ff;
      fin_data      = data_ff;
      push          = 1'b0;
      push_cmd.op   = OP_RECORD;
      push_cmd.kind = KIND_INPUT;
      push_cmd.id   = rep_id_ff;
      push_cmd.size = product[18:3];

      if (accept) begin
         unique case (in_func)
            FUNC_LOOKUP: begin
               push          = 1'b1;
               push_cmd.op   = OP_LOOKUP;
               push_cmd.kind = KIND_LOOKUP;
               push_cmd.id   = in_qid;
            end
            FUNC_CLEAR: begin
               push        = 1'b1;
               push_cmd.op = OP_CLEAR;
            end
            FUNC_BYTE: begin
               if (bytes_left_ff == 9'd0) begin
                  prefix_in   = in_byte;
                  data_idx_in = 2'd0;
                  data_in     = 32'd0;
                  if (in_byte == LONG_PREFIX) begin
                     bytes_left_in = 9'd1;
                  end else begin
                     bytes_left_in = (len == 2'd3) ? 9'd4 : {7'b0, len};
                     if (len == 2'd0) begin
                        finish     = 1'b1;
                        fin_prefix = in_byte;
                        fin_data   = 32'd0;
                     end
                  end
               end else if (prefix_ff == LONG_PREFIX) begin
                  // first byte after a long prefix holds the data length
                  if (data_idx_ff == 2'd0) begin
                     bytes_left_in = {1'b0, in_byte} + 9'd1;
                     data_idx_in   = 2'd1;
                  end else begin
                     bytes_left_in = bytes_left_ff - 9'd1;
                  end
               end else begin
                  data_in       = merged_data;
                  data_idx_in   = data_idx_ff + 2'd1;
                  bytes_left_in = bytes_left_ff - 9'd1;
                  if (bytes_left_ff == 9'd1) begin
                     finish     = 1'b1;
                     fin_prefix = prefix_ff;
                     fin_data   = merged_data;
                  end
               end

               if (finish) begin
                  unique case (fin_prefix & TAG_MASK)
                     TAG_REPORT_ID:    rep_id_in    = fin_data[7:0];
                     TAG_REPORT_SIZE:  rep_size_in  = fin_data[GLOB_W-1:0];
                     TAG_REPORT_COUNT: rep_count_in = fin_data[GLOB_W-1:0];
                     TAG_INPUT: begin
                        push          = 1'b1;
                        push_cmd.kind = KIND_INPUT;
                     end
                     TAG_OUTPUT: begin
                        push          = 1'b1;
                        push_cmd.kind = KIND_OUTPUT;
                     end
                     TAG_FEATURE: begin
                        push          = 1'b1;
                        push_cmd.kind = KIND_FEATURE;
                     end
                     default: ;
                  endcase
               end

               if (in_last) begin
                  bytes_left_in = 9'd0;
                  prefix_in     = 8'd0;
                  data_idx_in   = 2'd0;
                  data_in       = 32'd0;
                  rep_id_in     = 8'hFF;
                  rep_size_in   = {GLOB_W{1'b1}};
                  rep_count_in  = {GLOB_W{1'b1}};
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 9'd0;
         prefix_ff     <= 8'd0;
         data_idx_ff   <= 2'd0;
         data_ff       <= 32'd0;
         rep_id_ff     <= 8'hFF;
         rep_size_ff   <= {GLOB_W{1'b1}};
         rep_count_ff  <= {GLOB_W{1'b1}};
      end else begin
         bytes_left_ff <= bytes_left_in;
         prefix_ff     <= prefix_in;
         data_idx_ff   <= data_idx_in;
         data_ff       <= data_in;
         rep_id_ff     <= rep_id_in;
         rep_size_ff   <= rep_size_in;
         rep_count_ff  <= rep_count_in;
      end
   end

endmodule

@@ rtl/hrse_queue.sv @@
`include "assert_macros.svh"

module hrse_queue
   import hrse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `HRSE_ASSERT_NEVER(a_queue_overflow, clock, reset, push && full, "push into full queue")
   `HRSE_ASSERT_NEVER(a_queue_underflow, clock, reset, pop && empty, "pop from empty queue")

endmodule

@@ rtl/hrse_back.sv @@
`include "assert_macros.svh"

module hrse_back
   import hrse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    queue_empty,
   input  cmd_type head,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic [7:0]            ids_ff   [TABLE_DEPTH];
   logic [15:0]           sizes_ff [TABLE_DEPTH];
   logic [TBL_FILL_W-1:0] fill_ff, fill_in;
   back_state_type        state_ff, state_in;
   logic [TBL_IDX_W-1:0]  idx_ff, idx_in;
   logic [7:0]            qid_ff, qid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  out_free;
   logic                  tbl_we;
   logic                  emit;
   rsp_type               emit_rsp;
   logic                  hit;
   logic                  scan_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign hit       = (ids_ff[idx_ff] == qid_ff);
   assign scan_last = (TBL_FILL_W'(idx_ff) + TBL_FILL_W'(1)) == fill_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      qid_in   = qid_ff;
      fill_in  = fill_ff;
      pop      = 1'b0;
      tbl_we   = 1'b0;
      emit     = 1'b0;
      emit_rsp.kind      = KIND_LOOKUP;
      emit_rsp.report_id = qid_ff;
      emit_rsp.byte_size = 16'd0;
      emit_rsp.status    = STAT_OK;

      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty && out_free) begin
               pop = 1'b1;
               unique case (head.op)
                  OP_RECORD: begin
                     emit               = 1'b1;
                     emit_rsp.kind      = head.kind;
                     emit_rsp.report_id = head.id;
                     emit_rsp.byte_size = head.size;
                     if (fill_ff < TBL_FILL_W'(TABLE_DEPTH)) begin
                        tbl_we  = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end else begin
                        emit_rsp.status = STAT_FULL;
                     end
                  end
                  OP_LOOKUP: begin
                     if (fill_ff == '0) begin
                        emit               = 1'b1;
                        emit_rsp.report_id = head.id;
                        emit_rsp.status    = STAT_EMPTY;
                     end else begin
                        state_in = BK_SCAN;
                        idx_in   = '0;
                        qid_in   = head.id;
                     end
                  end
                  OP_CLEAR: fill_in = '0;
                  default: ;
               endcase
            end
         end
         BK_SCAN: begin
            // one table entry per cycle while the output register is free, first match wins
            if (out_free) begin
               if (hit) begin
                  emit               = 1'b1;
                  emit_rsp.byte_size = sizes_ff[idx_ff];
                  state_in           = BK_IDLE;
               end else if (scan_last) begin
                  emit            = 1'b1;
                  emit_rsp.status = STAT_NOT_FOUND;
                  state_in        = BK_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_rsp;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      qid_ff <= qid_in;
      rsp_ff <= rsp_in;
      if (tbl_we) begin
         ids_ff[fill_ff[TBL_IDX_W-1:0]]   <= head.id;
         sizes_ff[fill_ff[TBL_IDX_W-1:0]] <= head.size;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `HRSE_ASSERT_NEVER(a_fill_bound, clock, reset, fill_ff > TBL_FILL_W'(TABLE_DEPTH), "table fill beyond depth")
   `HRSE_ASSERT_NEVER(a_scan_range, clock, reset, state_ff == BK_SCAN && TBL_FILL_W'(idx_ff) >= fill_ff, "scan past filled entries")
   `HRSE_ASSERT(a_hit_answers, clock, reset, state_ff == BK_SCAN && out_free && hit |=> rsp_valid_ff && state_ff == BK_IDLE, "scan hit gave no answer")

endmodule

@@ rtl/hid_report_size_extractor.sv @@
// HID report size extractor.
// Request channel (req_*): one transaction per descriptor byte, table lookup or
// table clear, selected by req_tuser. req_tlast marks the final descriptor byte;
// after it the item framer and the report id/size/count globals return to
// their reset values while the report table is kept.
// Result channel (rsp_*): one transaction per Input/Output/Feature item (id,
// kind, size in bytes, table-full status) and one per lookup.
// Throughput: one request per cycle while the two-entry command queue between
// the byte framer and the table engine has room.
// A record or an empty-table answer is written into the command queue, popped by
// the table engine and registered in the output register that drives rsp_*.
// A lookup scans the table one entry per cycle while the output register is free,
// trying entries up to the first match or the fill count.
// Reset clears the framer, the queue, the fill count and the output valid flag
// and sets the id/size/count globals to all ones; no clearing pass is needed.
// When rsp_tready is low the result is held in the output register, the table
// engine stops, the queue fills and req_tready drops.
module hid_report_size_extractor
   import hrse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // desc_byte[7:0], query_id[15:8]
   input  logic [1:0]  req_tuser,   // func[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // report_id[7:0], byte_size[23:8], status[25:24]
   output logic [1:0]  rsp_tuser    // kind[1:0]
);

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   cmd_type head;
   rsp_type rsp;

   hrse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_func    (req_tuser),
      .in_byte    (req_tdata[7:0]),
      .in_last    (req_tlast),
      .in_qid     (req_tdata[15:8]),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   hrse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .empty    (queue_empty),
      .head     (head)
   );

   hrse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   assign rsp_tdata = {6'b0, rsp.status, rsp.byte_size, rsp.report_id};
   assign rsp_tuser = rsp.kind;

endmodule
